// File: hw/rtl/nsf_pkg.sv
// Types, codes and helper functions shared by the NMEA sentence framer.
package nsf_pkg;

    localparam int IdentDepth = 8;
    localparam int IdxBits    = $clog2(IdentDepth);
    localparam int LenBits    = 4;
    localparam logic [LenBits-1:0] LenMax = '1;

    typedef logic [IdentDepth-1:0][7:0] t_ident;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [2:0] frame_status;
        logic [2:0] sentence_kind;
        logic [7:0] computed_sum;
    } t_out_item;

    localparam logic [2:0] ST_CSUM_OK    = 3'd0;
    localparam logic [2:0] ST_OK_NO_CSUM = 3'd1;
    localparam logic [2:0] ST_BAD_CSUM   = 3'd2;
    localparam logic [2:0] ST_NO_START   = 3'd3;
    localparam logic [2:0] ST_MALFORMED  = 3'd4;

    localparam logic [2:0] KIND_RMC     = 3'd0;
    localparam logic [2:0] KIND_GGA     = 3'd1;
    localparam logic [2:0] KIND_TXT     = 3'd2;
    localparam logic [2:0] KIND_PMTK001 = 3'd3;
    localparam logic [2:0] KIND_PMTK010 = 3'd4;
    localparam logic [2:0] KIND_PMTK011 = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [23:0] SUF_RMC = "RMC";
    localparam logic [23:0] SUF_GGA = "GGA";
    localparam logic [23:0] SUF_TXT = "TXT";
    localparam logic [55:0] ID_PMTK001 = "PMTK001";
    localparam logic [55:0] ID_PMTK010 = "PMTK010";
    localparam logic [55:0] ID_PMTK011 = "PMTK011";

    // Uppercase ASCII hex digit of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = 8'h30 + {4'h0, nib};
        end else begin
            hex_char = 8'h37 + {4'h0, nib};
        end
    endfunction

    // Entry 0 holds the first character of the identifier.
    function automatic logic [2:0] classify(input t_ident id, input logic [LenBits-1:0] len);
        logic [23:0] suf;
        logic [55:0] full;
        suf  = {id[2], id[3], id[4]};
        full = {id[0], id[1], id[2], id[3], id[4], id[5], id[6]};
        classify = KIND_UNKNOWN;
        if (len == LenBits'(5)) begin
            if (suf == SUF_RMC) begin
                classify = KIND_RMC;
            end else if (suf == SUF_GGA) begin
                classify = KIND_GGA;
            end else if (suf == SUF_TXT) begin
                classify = KIND_TXT;
            end
        end else if (len == LenBits'(7)) begin
            if (full == ID_PMTK001) begin
                classify = KIND_PMTK001;
            end else if (full == ID_PMTK010) begin
                classify = KIND_PMTK010;
            end else if (full == ID_PMTK011) begin
                classify = KIND_PMTK011;
            end
        end
    endfunction

endpackage

// File: hw/rtl/nsf_stream_if.sv
// Valid/ready stream channel carrying one item of a given payload type.
interface nsf_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/nmea_sentence_framer.sv
// NMEA sentence framer: one character per item in, one status item per sentence out.
//
// Characters enter an input register and are processed from there, so one character can
// be accepted every clock cycle unless a last character waits there for a stalled output.
// The status item of a sentence is written into the output register at the edge at which
// its last character leaves the input register. A stalled output only holds back a pending
// last character; ordinary characters keep flowing while a result waits.
module nmea_sentence_framer
    import nsf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsf_stream_if.sink    i_char,
    nsf_stream_if.source  o_frame
);

    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [7:0]            r_xor, n_xor;
    logic                  r_first_pending, n_first_pending;
    logic                  r_began_start, n_began_start;
    logic                  r_star_seen, n_star_seen;
    logic [1:0]            r_after_star, n_after_star;
    logic [1:0][7:0]       r_hex, n_hex;
    t_ident                r_id_rst, n_id_rst;
    logic [LenBits-1:0]    r_id_rst_len, n_id_rst_len;
    t_ident                r_id_sec, n_id_sec;
    logic [LenBits-1:0]    r_id_sec_len, n_id_sec_len;
    logic [1:0]            r_closed, n_closed;
    t_out_item             n_out;

    logic                  w_is_start;
    logic                  w_slot_free;
    logic                  w_proc;
    logic                  w_in_ready;
    logic [7:0]            w_c;

    assign w_slot_free = !r_out_valid || o_frame.ready;
    assign w_proc      = r_in_valid && (!r_in.last_char || w_slot_free);
    assign w_in_ready  = !r_in_valid || w_proc;

    assign i_char.ready    = w_in_ready;
    assign o_frame.valid   = r_out_valid;
    assign o_frame.payload = r_out;

    assign w_c        = r_in.char_in;
    assign w_is_start = (w_c == CH_DOLLAR) || (w_c == CH_BANG);

    always_comb begin
        n_xor           = r_xor;
        n_first_pending = r_first_pending;
        n_began_start   = r_began_start;
        n_star_seen     = r_star_seen;
        n_after_star    = r_after_star;
        n_hex           = r_hex;
        n_id_rst        = r_id_rst;
        n_id_rst_len    = r_id_rst_len;
        n_id_sec        = r_id_sec;
        n_id_sec_len    = r_id_sec_len;
        n_closed        = r_closed;

        if (r_first_pending) begin
            n_began_start   = w_is_start;
            n_first_pending = 1'b0;
        end else if (!r_closed[1]) begin
            if (w_c == CH_COMMA) begin
                n_closed[1] = 1'b1;
            end else begin
                if (r_id_sec_len < LenBits'(IdentDepth)) begin
                    n_id_sec[r_id_sec_len[IdxBits-1:0]] = w_c;
                end
                if (r_id_sec_len != LenMax) begin
                    n_id_sec_len = r_id_sec_len + LenBits'(1);
                end
            end
        end

        if (r_star_seen) begin
            if (r_after_star < 2'd2) begin
                n_hex[r_after_star[0]] = w_c;
                n_after_star           = r_after_star + 2'd1;
            end
        end else if (w_c == CH_STAR) begin
            n_star_seen = 1'b1;
            n_closed[0] = 1'b1;
        end else if (w_is_start) begin
            n_xor        = '0;
            n_id_rst_len = '0;
            n_closed[0]  = 1'b0;
        end else begin
            n_xor = r_xor ^ w_c;
            if (!r_closed[0]) begin
                if (w_c == CH_COMMA) begin
                    n_closed[0] = 1'b1;
                end else begin
                    if (r_id_rst_len < LenBits'(IdentDepth)) begin
                        n_id_rst[r_id_rst_len[IdxBits-1:0]] = w_c;
                    end
                    if (r_id_rst_len != LenMax) begin
                        n_id_rst_len = r_id_rst_len + LenBits'(1);
                    end
                end
            end
        end

        n_out.computed_sum  = n_xor;
        n_out.sentence_kind = KIND_UNKNOWN;
        if (n_star_seen && (n_after_star == 2'd2)) begin
            if ((n_hex[0] == hex_char(n_xor[7:4])) && (n_hex[1] == hex_char(n_xor[3:0]))) begin
                n_out.frame_status  = ST_CSUM_OK;
                n_out.sentence_kind = classify(n_id_rst, n_id_rst_len);
            end else begin
                n_out.frame_status = ST_BAD_CSUM;
            end
        end else if (!n_began_start) begin
            n_out.frame_status = ST_NO_START;
        end else if (n_star_seen) begin
            n_out.frame_status = ST_MALFORMED;
        end else begin
            n_out.frame_status  = ST_OK_NO_CSUM;
            n_out.sentence_kind = classify(n_id_sec, n_id_sec_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_xor           <= '0;
            r_first_pending <= 1'b1;
            r_began_start   <= 1'b0;
            r_star_seen     <= 1'b0;
            r_after_star    <= '0;
            r_id_rst_len    <= '0;
            r_id_sec_len    <= '0;
            r_closed        <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_char.valid;
            end
            if (w_proc && r_in.last_char) begin
                r_out_valid     <= 1'b1;
                r_xor           <= '0;
                r_first_pending <= 1'b1;
                r_began_start   <= 1'b0;
                r_star_seen     <= 1'b0;
                r_after_star    <= '0;
                r_id_rst_len    <= '0;
                r_id_sec_len    <= '0;
                r_closed        <= '0;
            end else begin
                if (o_frame.ready) begin
                    r_out_valid <= 1'b0;
                end
                if (w_proc) begin
                    r_xor           <= n_xor;
                    r_first_pending <= n_first_pending;
                    r_began_start   <= n_began_start;
                    r_star_seen     <= n_star_seen;
                    r_after_star    <= n_after_star;
                    r_id_rst_len    <= n_id_rst_len;
                    r_id_sec_len    <= n_id_sec_len;
                    r_closed        <= n_closed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready) begin
            r_in <= i_char.payload;
        end
        if (w_proc) begin
            r_hex    <= n_hex;
            r_id_rst <= n_id_rst;
            r_id_sec <= n_id_sec;
        end
        if (w_proc && r_in.last_char) begin
            r_out <= n_out;
        end
    end

    // A new result only appears after the last character of a sentence was processed.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_proc && r_in.last_char))
        else $error("result raised without a processed last character");

    // Sentence state returns to its start after each last character.
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.last_char) |=> (r_first_pending && !r_star_seen && (r_xor == 8'h00)))
        else $error("sentence state not cleared after last character");

    // Checksum digits are only collected after the asterisk.
    a_digits_after_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_after_star != 2'd0) |-> r_star_seen)
        else $error("checksum digits counted without an asterisk");

    // Error results never carry a sentence kind.
    a_error_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out.frame_status == ST_BAD_CSUM)
                      || (r_out.frame_status == ST_NO_START)
                      || (r_out.frame_status == ST_MALFORMED)))
        |-> (r_out.sentence_kind == KIND_UNKNOWN))
        else $error("error result with a known sentence kind");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the NMEA sentence framer with a built-in sentence predictor.
module tb
    import nsf_pkg::*;
;

    typedef logic [7:0] t_bytes [$];
    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} t_rdy_mode;

    localparam int IdRestart     = 0;
    localparam int IdSecond      = 1;
    localparam int IdBufDepth    = 8;
    localparam int TotalItems    = 1500;
    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 8;
    localparam int MaxPrinted    = 50;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nsf_stream_if #(.t_payload(t_in_item))  char_if ();
    nsf_stream_if #(.t_payload(t_out_item)) frame_if ();

    nmea_sentence_framer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if.sink),
        .o_frame (frame_if.source)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  pending_chars [$];
    t_out_item expected_frames [$];
    int        error_count = 0;
    int        frames_seen = 0;
    int        idle_cycles = 0;
    logic      char_took = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    t_rdy_mode rdy_mode = RDY_ALWAYS;
    int        rdy_left = 0;

    logic [7:0] specials [4] = '{CH_DOLLAR, CH_BANG, CH_STAR, CH_COMMA};
    string ident_pool [7] = '{"GPRMC", "GNGGA", "GPTXT", "PMTK001", "PMTK010", "PMTK011",
                              "GPGSV"};

    // Sentence state of the predictor.
    logic [7:0] sn_sum;
    logic       sn_first;
    logic       sn_began;
    logic       sn_star;
    logic [1:0] sn_after;
    logic [7:0] sn_digits [2];
    logic [7:0] id_buf [2][IdBufDepth];
    logic [3:0] id_len [2];
    logic       id_closed [2];

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        hex_digit = (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
    endfunction

    task automatic clear_sentence_state();
        sn_sum = 8'h00;
        sn_first = 1'b1;
        sn_began = 1'b0;
        sn_star = 1'b0;
        sn_after = 2'd0;
        for (int k = 0; k < 2; k++) begin
            sn_digits[k] = 8'h00;
            id_len[k] = 4'd0;
            id_closed[k] = 1'b0;
            for (int j = 0; j < IdBufDepth; j++) begin
                id_buf[k][j] = 8'h00;
            end
        end
    endtask

    task automatic grab_ident(input int which, input logic [7:0] c);
        if (id_len[which] < 4'd8) begin
            id_buf[which][id_len[which]] = c;
        end
        if (id_len[which] != 4'hF) begin
            id_len[which]++;
        end
    endtask

    function automatic logic [2:0] kind_of(input int which);
        logic [23:0] tail;
        logic [55:0] whole;
        tail = {id_buf[which][2], id_buf[which][3], id_buf[which][4]};
        whole = {id_buf[which][0], id_buf[which][1], id_buf[which][2], id_buf[which][3],
                 id_buf[which][4], id_buf[which][5], id_buf[which][6]};
        kind_of = KIND_UNKNOWN;
        if (id_len[which] == 4'd5) begin
            if (tail == "RMC") begin
                kind_of = KIND_RMC;
            end else if (tail == "GGA") begin
                kind_of = KIND_GGA;
            end else if (tail == "TXT") begin
                kind_of = KIND_TXT;
            end
        end else if (id_len[which] == 4'd7) begin
            if (whole == "PMTK001") begin
                kind_of = KIND_PMTK001;
            end else if (whole == "PMTK010") begin
                kind_of = KIND_PMTK010;
            end else if (whole == "PMTK011") begin
                kind_of = KIND_PMTK011;
            end
        end
    endfunction

    task automatic frame_char(input t_in_item it);
        logic [7:0] c;
        logic       start_ch;
        t_out_item  r;
        c = it.char_in;
        start_ch = (c == CH_DOLLAR) || (c == CH_BANG);
        if (sn_first) begin
            sn_began = start_ch;
            sn_first = 1'b0;
        end else if (!id_closed[IdSecond]) begin
            if (c == CH_COMMA) begin
                id_closed[IdSecond] = 1'b1;
            end else begin
                grab_ident(IdSecond, c);
            end
        end
        if (sn_star) begin
            if (sn_after < 2'd2) begin
                sn_digits[sn_after] = c;
                sn_after++;
            end
        end else if (c == CH_STAR) begin
            sn_star = 1'b1;
            id_closed[IdRestart] = 1'b1;
        end else if (start_ch) begin
            sn_sum = 8'h00;
            id_len[IdRestart] = 4'd0;
            id_closed[IdRestart] = 1'b0;
        end else begin
            sn_sum ^= c;
            if (!id_closed[IdRestart]) begin
                if (c == CH_COMMA) begin
                    id_closed[IdRestart] = 1'b1;
                end else begin
                    grab_ident(IdRestart, c);
                end
            end
        end
        if (it.last_char) begin
            r.sentence_kind = KIND_UNKNOWN;
            r.computed_sum = sn_sum;
            if (sn_star && sn_after == 2'd2) begin
                if (sn_digits[0] == hex_digit(sn_sum[7:4]) &&
                    sn_digits[1] == hex_digit(sn_sum[3:0])) begin
                    r.frame_status = ST_CSUM_OK;
                    r.sentence_kind = kind_of(IdRestart);
                end else begin
                    r.frame_status = ST_BAD_CSUM;
                end
            end else if (!sn_began) begin
                r.frame_status = ST_NO_START;
            end else if (sn_star) begin
                r.frame_status = ST_MALFORMED;
            end else begin
                r.frame_status = ST_OK_NO_CSUM;
                r.sentence_kind = kind_of(IdSecond);
            end
            expected_frames.push_back(r);
            clear_sentence_state();
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < MaxPrinted) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic t_bytes bs(input string s);
        t_bytes q;
        for (int k = 0; k < s.len(); k++) begin
            q.push_back(s[k]);
        end
        return q;
    endfunction

    function automatic t_bytes with_sum(input t_bytes head, input t_bytes body);
        logic [7:0] x;
        x = 8'h00;
        foreach (body[k]) begin
            x ^= body[k];
        end
        return {head, body, CH_STAR, hex_digit(x[7:4]), hex_digit(x[3:0])};
    endfunction

    task automatic send_sentence(input t_bytes s);
        t_in_item it;
        foreach (s[k]) begin
            it.char_in = s[k];
            it.last_char = (k == s.size() - 1);
            pending_chars.push_back(it);
        end
    endtask

    function automatic logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) begin
            c = 8'($urandom_range(0, 255));
        end else begin
            c = 8'($urandom_range(8'h20, 8'h7E));
        end
        if (c == CH_DOLLAR || c == CH_BANG || c == CH_STAR) begin
            c = CH_COMMA;
        end
        return c;
    endfunction

    task automatic add_random_sentence();
        t_bytes lead;
        t_bytes body;
        t_bytes s;
        int     form;
        int     mode;
        form = $urandom_range(0, 99);
        if (form < 15) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 3) == 0) begin
                    s.push_back(specials[$urandom_range(0, 3)]);
                end else begin
                    s.push_back(8'($urandom_range(0, 255)));
                end
            end
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                lead = bs("$XY,");
                repeat ($urandom_range(0, 4)) lead.push_back(field_char());
            end
            mode = $urandom_range(0, 9);
            if (mode == 1 || mode == 2) begin
                lead.push_back(CH_BANG);
            end else if (mode > 2) begin
                lead.push_back(CH_DOLLAR);
            end
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                body = bs(ident_pool[mode]);
            end else begin
                repeat ($urandom_range(0, 10)) body.push_back(field_char());
            end
            repeat ($urandom_range(0, 4)) begin
                body.push_back(CH_COMMA);
                repeat ($urandom_range(0, 6)) body.push_back(field_char());
            end
            mode = $urandom_range(0, 19);
            if (mode < 13) begin
                s = with_sum(lead, body);
            end else if (mode < 15) begin
                s = with_sum(lead, body);
                s[s.size() - 1] ^= 8'h01;
            end else if (mode < 17) begin
                s = {lead, body};
            end else if (mode == 17) begin
                s = with_sum(lead, body);
                s[s.size() - 1] |= 8'h20;
                s[s.size() - 2] |= 8'h20;
            end else begin
                s = {lead, body, CH_STAR};
                if (mode == 19) begin
                    s.push_back(hex_digit(4'($urandom_range(0, 15))));
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (s.size() == 0) begin
            s.push_back(CH_DOLLAR);
        end
        send_sentence(s);
    endtask

    initial begin
        t_bytes s;
        i_rst_n = 1'b0;
        char_if.valid = 1'b0;
        char_if.payload = '0;
        frame_if.ready = 1'b0;
        clear_sentence_state();

        send_sentence(with_sum(bs("$"), bs("GPRMC,123519,A")));
        send_sentence(with_sum(bs("!"), bs("AIGGA,5")));
        send_sentence(with_sum(bs("$"), bs("GPTXT,01")));
        send_sentence(with_sum(bs("$"), bs("PMTK001,604,3")));
        send_sentence(with_sum(bs("$"), bs("PMTK010,002")));
        send_sentence(with_sum(bs("$"), bs("PMTK011,MTKGPS")));
        send_sentence(with_sum(bs("$"), bs("GPGSV,3")));
        send_sentence(bs("$GPGGA,1,2"));
        send_sentence(bs("!PMTK011"));
        send_sentence(bs("$GPRMC"));
        s = with_sum(bs("$"), bs("GNRMC,1"));
        s[s.size() - 1] ^= 8'h01;
        send_sentence(s);
        send_sentence(bs("$GPRMC*4b"));
        send_sentence(bs("GPRMC,1"));
        send_sentence(with_sum(bs(""), bs("GPRMC")));
        send_sentence(bs("$GPRMC*4"));
        send_sentence(bs("$GPGGA*"));
        send_sentence(with_sum(bs("$GPXX,1$"), bs("GPRMC,2")));
        send_sentence(bs("$GPRMC$*00"));
        send_sentence({with_sum(bs("$"), bs("GPGGA,7")), bs("\r\n")});
        send_sentence(with_sum(bs("$"), '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA}));
        send_sentence(bs("$"));
        send_sentence(bs("A"));
        send_sentence(with_sum(bs("$"), bs("GPRMCXXXX,1")));
        send_sentence(bs("$ABCDEFGHIJKLMNOPQRS"));
        send_sentence(bs("GP*"));

        while (pending_chars.size() < TotalItems) begin
            add_random_sentence();
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || char_if.valid || expected_frames.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(negedge i_clk) begin : drive_proc
        t_in_item nxt_item;
        logic     nxt_valid;
        logic     nxt_ready;
        nxt_valid = char_if.valid;
        nxt_item = char_if.payload;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!char_if.valid || char_took) begin
            nxt_valid = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_chars.size() != 0) begin
                nxt_item = pending_chars.pop_front();
                nxt_valid = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
        char_if.valid <= nxt_valid;
        char_if.payload <= nxt_item;

        if (rdy_left == 0) begin
            rdy_mode = t_rdy_mode'($urandom_range(0, 3));
            rdy_left = $urandom_range(10, 80);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            RDY_ALWAYS: nxt_ready = 1'b1;
            RDY_COIN:   nxt_ready = 1'($urandom_range(0, 1));
            RDY_SPARSE: nxt_ready = ($urandom_range(0, 5) == 0);
            default:    nxt_ready = !frame_if.ready;
        endcase
        frame_if.ready <= nxt_ready;
    end

    always @(posedge i_clk) begin : observe_proc
        t_out_item got;
        t_out_item want;
        char_took = 1'b0;
        if (i_rst_n) begin
            if (char_if.valid && char_if.ready) begin
                char_took = 1'b1;
                frame_char(char_if.payload);
            end
            if (frame_if.valid && frame_if.ready) begin
                got = frame_if.payload;
                frames_seen++;
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("frame %0d arrived with none expected", frames_seen));
                end else begin
                    want = expected_frames.pop_front();
                    if (got.frame_status !== want.frame_status) begin
                        report_mismatch($sformatf("frame %0d frame_status %0d, expected %0d",
                                                  frames_seen, got.frame_status,
                                                  want.frame_status));
                    end
                    if (got.sentence_kind !== want.sentence_kind) begin
                        report_mismatch($sformatf("frame %0d sentence_kind %0d, expected %0d",
                                                  frames_seen, got.sentence_kind,
                                                  want.sentence_kind));
                    end
                    if (got.computed_sum !== want.computed_sum) begin
                        report_mismatch($sformatf("frame %0d computed_sum %h, expected %h",
                                                  frames_seen, got.computed_sum,
                                                  want.computed_sum));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (char_if.valid && char_if.ready) ||
            (frame_if.valid && frame_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
